// ----- rtl/lzss4k_pkg.sv -----
// Shared types and constants for the LZSS 4K-window decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package lzss4k_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FLAGCNT_W   = 4;
    localparam int unsigned RUN_W       = 5;
    localparam int unsigned DIST_W      = 13;
    localparam int unsigned OFFSET_W    = 12;

    localparam logic [FLAGCNT_W-1:0] FLAG_GROUP = 4'd8;
    localparam logic [RUN_W-1:0]     RUN_BIAS   = 5'd3;

    localparam logic FMT_COUNT_HIGH = 1'b0;
    localparam logic FMT_COUNT_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_FLAG,
        ST_TOKEN,
        ST_SECOND,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_flags;
        logic load_first;
        logic emit_literal;
        logic start_copy;
        logic issue_read;
        logic emit_copy;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic flag_bit;
        logic flag_last;
        logic group_done;
        logic copy_end;
        logic last_pending;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/lzss4k_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module lzss4k_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzss4k_ctrl.sv -----
// Token sequencer: walks flag groups, literals and reference copies.
// Depends on lzss4k_pkg; drives datapath commands from its status.
`default_nettype none

module lzss4k_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tlast,
    output logic                     s_tready,
    input  wire lzss4k_pkg::status_t st,
    output lzss4k_pkg::cmd_t         cmd
);

    lzss4k_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lzss4k_pkg::ST_FLAG;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lzss4k_pkg::ST_FLAG: begin
                s_tready = st.out_free;
                if (s_tvalid && st.out_free) begin
                    cmd.load_flags = 1'b1;
                    cmd.clear      = s_tlast;
                    state_next     = s_tlast ? lzss4k_pkg::ST_FLAG : lzss4k_pkg::ST_TOKEN;
                end
            end
            lzss4k_pkg::ST_TOKEN: begin
                s_tready = st.out_free;
                if (s_tvalid && st.out_free) begin
                    cmd.clear = s_tlast;
                    if (st.flag_bit) begin
                        cmd.load_first = 1'b1;
                        state_next = s_tlast ? lzss4k_pkg::ST_FLAG : lzss4k_pkg::ST_SECOND;
                    end else begin
                        cmd.emit_literal = 1'b1;
                        state_next = (s_tlast || st.flag_last) ? lzss4k_pkg::ST_FLAG
                                                               : lzss4k_pkg::ST_TOKEN;
                    end
                end
            end
            lzss4k_pkg::ST_SECOND: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start_copy = 1'b1;
                    state_next     = lzss4k_pkg::ST_READ;
                end
            end
            lzss4k_pkg::ST_READ: begin
                cmd.issue_read = 1'b1;
                state_next     = lzss4k_pkg::ST_EMIT;
            end
            lzss4k_pkg::ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit_copy = 1'b1;
                    if (st.copy_end) begin
                        cmd.clear  = st.last_pending;
                        state_next = (st.last_pending || st.group_done)
                                     ? lzss4k_pkg::ST_FLAG : lzss4k_pkg::ST_TOKEN;
                    end else begin
                        state_next = lzss4k_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = lzss4k_pkg::ST_FLAG;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lzss4k_dp.sv -----
// Datapath: flag shifter, history pointers, copy counters, output register.
// Depends on lzss4k_pkg and lzss4k_ram; acts on lzss4k_ctrl commands.
`default_nettype none

module lzss4k_dp #(
    parameter int unsigned WINDOW_DEPTH = 4096
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_wdata,
    input  wire logic [7:0]                s_tdata,
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [7:0]                m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser,
    input  wire lzss4k_pkg::cmd_t          cmd,
    output lzss4k_pkg::status_t            st
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned SW = AW + 1;
    localparam int unsigned PW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW-1:0] PTR_MAX = AW'(WINDOW_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S = SW'(WINDOW_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(WINDOW_DEPTH);

    logic                                  fmt_reg;
    logic [lzss4k_pkg::BYTE_W-1:0]         flag_bits_reg;
    logic [lzss4k_pkg::FLAGCNT_W-1:0]      flags_left_reg;
    logic [lzss4k_pkg::BYTE_W-1:0]         first_reg;
    logic [AW-1:0]                         wp_reg;
    logic [PW-1:0]                         produced_reg;
    logic [lzss4k_pkg::RUN_W-1:0]          remain_reg;
    logic [lzss4k_pkg::DIST_W-1:0]         dist_reg;
    logic                                  last_pending_reg;
    logic                                  m_valid_reg;
    logic [7:0]                            m_data_reg;
    logic                                  m_last_reg;
    logic                                  m_bad_reg;

    logic [lzss4k_pkg::RUN_W-1:0]          count_new;
    logic [lzss4k_pkg::OFFSET_W-1:0]       offset_new;
    logic [SW-1:0]                         wp_s;
    logic [SW-1:0]                         dist_s;
    logic [SW-1:0]                         src_s;
    logic [AW-1:0]                         src_addr;
    logic                                  bad_ref;
    logic [7:0]                            ram_rdata;
    logic [7:0]                            copy_byte;
    logic                                  ram_we;
    logic [7:0]                            ram_wdata;
    logic                                  out_free;
    logic                                  advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = cmd.emit_literal || cmd.start_copy;
    assign ram_we   = cmd.emit_literal || cmd.emit_copy;

    always_comb begin
        if (fmt_reg == lzss4k_pkg::FMT_COUNT_LOW) begin
            count_new  = {1'b0, first_reg[3:0]} + lzss4k_pkg::RUN_BIAS;
            offset_new = {first_reg[7:4], s_tdata};
        end else begin
            count_new  = {1'b0, first_reg[7:4]} + lzss4k_pkg::RUN_BIAS;
            offset_new = {first_reg[3:0], s_tdata};
        end
    end

    assign wp_s   = {1'b0, wp_reg};
    assign dist_s = SW'(dist_reg);

    always_comb begin
        if (wp_s >= dist_s) begin
            src_s = wp_s - dist_s;
        end else begin
            src_s = wp_s + DEPTH_S - dist_s;
        end
    end

    assign src_addr  = src_s[AW-1:0];
    assign bad_ref   = PW'(dist_reg) > produced_reg;
    assign copy_byte = bad_ref ? 8'd0 : ram_rdata;
    assign ram_wdata = cmd.emit_literal ? s_tdata : copy_byte;

    lzss4k_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (cmd.issue_read),
        .raddr (src_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg          <= 1'b0;
            flag_bits_reg    <= '0;
            flags_left_reg   <= '0;
            first_reg        <= '0;
            wp_reg           <= '0;
            produced_reg     <= '0;
            remain_reg       <= '0;
            dist_reg         <= '0;
            last_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                fmt_reg <= cfg_wdata;
            end
            if (cmd.load_flags) begin
                flag_bits_reg  <= s_tdata;
                flags_left_reg <= lzss4k_pkg::FLAG_GROUP;
            end else if (advance) begin
                flag_bits_reg <= flag_bits_reg >> 1;
                if (flags_left_reg != '0) begin
                    flags_left_reg <= flags_left_reg - 1'b1;
                end
            end
            if (cmd.load_first) begin
                first_reg <= s_tdata;
            end
            if (cmd.start_copy) begin
                remain_reg       <= count_new;
                dist_reg         <= {1'b0, offset_new} + 1'b1;
                last_pending_reg <= s_tlast;
            end else if (cmd.emit_copy) begin
                remain_reg <= remain_reg - 1'b1;
            end
            if (ram_we) begin
                wp_reg <= (wp_reg == PTR_MAX) ? '0 : wp_reg + 1'b1;
                if (produced_reg != DEPTH_P) begin
                    produced_reg <= produced_reg + 1'b1;
                end
            end
            if (cmd.clear) begin
                flag_bits_reg  <= '0;
                flags_left_reg <= '0;
                first_reg      <= '0;
                wp_reg         <= '0;
                produced_reg   <= '0;
            end
            if (ram_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_literal) begin
            m_data_reg <= s_tdata;
            m_last_reg <= 1'b1;
            m_bad_reg  <= 1'b0;
        end else if (cmd.emit_copy) begin
            m_data_reg <= copy_byte;
            m_last_reg <= (remain_reg == lzss4k_pkg::RUN_W'(1));
            m_bad_reg  <= bad_ref;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

    assign st.flag_bit     = flag_bits_reg[0];
    assign st.flag_last    = (flags_left_reg == lzss4k_pkg::FLAGCNT_W'(1));
    assign st.group_done   = (flags_left_reg == '0);
    assign st.copy_end     = (remain_reg == lzss4k_pkg::RUN_W'(1));
    assign st.last_pending = last_pending_reg;
    assign st.out_free     = out_free;

endmodule

`default_nettype wire

// ----- rtl/lzss4k_window_decompressor.sv -----
// LZSS decompressor, 4K history window. A literal is written into the history
// RAM and the output register together. A reference of N bytes (3..18) is
// copied byte by byte: each byte is a history read then a write through the
// one RAM read/write port pair.
// Reset is synchronous, active low, clears control state; the history RAM is
// not cleared, reads beyond produced data return zero with m_tuser set.
`default_nettype none

module lzss_4k_window_decompressor #(
    parameter int unsigned WINDOW_DEPTH = 4096
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,   // format_select
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,     // out_byte
    output logic            m_tlast,
    output logic            m_tuser      // bad_reference
);

    lzss4k_pkg::cmd_t    cmd;
    lzss4k_pkg::status_t st;

    lzss4k_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lzss4k_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .st        (st)
    );

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_flags, cmd.load_first, cmd.emit_literal,
                  cmd.start_copy, cmd.issue_read, cmd.emit_copy}))
        else $error("datapath commands overlap");

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
        else $error("bad reference byte not zero");

    a_copy_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_copy |=> cmd.issue_read)
        else $error("copy did not start with a history read");

    a_no_input_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_read |=> !s_tready)
        else $error("input taken during a copy");

endmodule

`default_nettype wire
